@@ rtl/xml_entity_decoder_macros.svh @@
//------------------------------------------------------------------------------
// XML entity decoder assertion macros
// Shorthand for the clocked, reset-qualified checks used by the checker.
//------------------------------------------------------------------------------
`ifndef XML_ENTITY_DECODER_MACROS_SVH
`define XML_ENTITY_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XED_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xml entity decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define XED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xml entity decoder check failed");

`endif

@@ rtl/xed_pkg.sv @@
//------------------------------------------------------------------------------
// XML entity decoder package
// Trie node codes, burst record and the spelling tables of the six entities.
//------------------------------------------------------------------------------
package xed_pkg;

   localparam int unsigned MaxBurst = 6;

   typedef enum logic [4:0] {
      N_NONE = 5'd0,
      N_AMP  = 5'd1,
      N_L    = 5'd2,
      N_LT   = 5'd3,
      N_G    = 5'd4,
      N_GT   = 5'd5,
      N_A    = 5'd6,
      N_AM   = 5'd7,
      N_AMP_NAME = 5'd8,
      N_AP   = 5'd9,
      N_APO  = 5'd10,
      N_APOS = 5'd11,
      N_Q    = 5'd12,
      N_QU   = 5'd13,
      N_QUO  = 5'd14,
      N_QUOT = 5'd15,
      N_N    = 5'd16,
      N_NB   = 5'd17,
      N_NBS  = 5'd18,
      N_NBSP = 5'd19
   } node_type;

   typedef logic [MaxBurst-1:0][7:0] text_type;

   typedef struct packed {
      text_type   bytes;
      logic [2:0] count;
      logic       text_end;
   } burst_type;

   function automatic node_type child(input node_type node, input logic [7:0] b);
      node_type r;
      r = N_NONE;
      case (node)
         N_AMP: begin
            if (b == "l") r = N_L;
            else if (b == "g") r = N_G;
            else if (b == "a") r = N_A;
            else if (b == "q") r = N_Q;
            else if (b == "n") r = N_N;
         end
         N_L:   if (b == "t") r = N_LT;
         N_G:   if (b == "t") r = N_GT;
         N_A: begin
            if (b == "m") r = N_AM;
            else if (b == "p") r = N_AP;
         end
         N_AM:  if (b == "p") r = N_AMP_NAME;
         N_AP:  if (b == "o") r = N_APO;
         N_APO: if (b == "s") r = N_APOS;
         N_Q:   if (b == "u") r = N_QU;
         N_QU:  if (b == "o") r = N_QUO;
         N_QUO: if (b == "t") r = N_QUOT;
         N_N:   if (b == "b") r = N_NB;
         N_NB:  if (b == "s") r = N_NBS;
         N_NBS: if (b == "p") r = N_NBSP;
         default: r = N_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] decode(input node_type node);
      logic [7:0] r;
      case (node)
         N_LT:       r = "<";
         N_GT:       r = ">";
         N_AMP_NAME: r = "&";
         N_APOS:     r = 8'h27;
         N_QUOT:     r = 8'h22;
         N_NBSP:     r = " ";
         default:    r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] node_len(input node_type node);
      logic [2:0] r;
      case (node)
         N_AMP:                              r = 3'd1;
         N_L, N_G, N_A, N_Q, N_N:            r = 3'd2;
         N_LT, N_GT, N_AM, N_AP, N_QU, N_NB: r = 3'd3;
         N_AMP_NAME, N_APO, N_QUO, N_NBS:    r = 3'd4;
         N_APOS, N_QUOT, N_NBSP:             r = 3'd5;
         default:                            r = 3'd0;
      endcase
      return r;
   endfunction

   // Byte 0 of the result holds the first character of the spelling.
   function automatic text_type node_text(input node_type node);
      text_type r;
      case (node)
         N_AMP:      r = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "&"};
         N_L:        r = {8'h00, 8'h00, 8'h00, 8'h00, "l", "&"};
         N_LT:       r = {8'h00, 8'h00, 8'h00, "t", "l", "&"};
         N_G:        r = {8'h00, 8'h00, 8'h00, 8'h00, "g", "&"};
         N_GT:       r = {8'h00, 8'h00, 8'h00, "t", "g", "&"};
         N_A:        r = {8'h00, 8'h00, 8'h00, 8'h00, "a", "&"};
         N_AM:       r = {8'h00, 8'h00, 8'h00, "m", "a", "&"};
         N_AMP_NAME: r = {8'h00, 8'h00, "p", "m", "a", "&"};
         N_AP:       r = {8'h00, 8'h00, 8'h00, "p", "a", "&"};
         N_APO:      r = {8'h00, 8'h00, "o", "p", "a", "&"};
         N_APOS:     r = {8'h00, "s", "o", "p", "a", "&"};
         N_Q:        r = {8'h00, 8'h00, 8'h00, 8'h00, "q", "&"};
         N_QU:       r = {8'h00, 8'h00, 8'h00, "u", "q", "&"};
         N_QUO:      r = {8'h00, 8'h00, "o", "u", "q", "&"};
         N_QUOT:     r = {8'h00, "t", "o", "u", "q", "&"};
         N_N:        r = {8'h00, 8'h00, 8'h00, 8'h00, "n", "&"};
         N_NB:       r = {8'h00, 8'h00, 8'h00, "b", "n", "&"};
         N_NBS:      r = {8'h00, 8'h00, "s", "b", "n", "&"};
         N_NBSP:     r = {8'h00, "p", "s", "b", "n", "&"};
         default:    r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/xml_entity_decoder.sv @@
//------------------------------------------------------------------------------
// XML entity decoder
// Streaming decoder for the entities lt, gt, amp, quot, apos and nbsp.
//------------------------------------------------------------------------------
// Requests carry one byte of escaped text (req_in_byte) and an end-of-text
// flag (req_in_end) on a valid/ready channel. Each request yields zero to six
// decoded bytes on the rsp_ channel; rsp_run_last marks the last byte caused
// by a request and rsp_text_end the final byte of the text.
// A request is decoded in the cycle it is accepted and its bytes appear on
// the response port from the next cycle, one byte per cycle while rsp_ready
// is high. A request that only extends a partial entity produces no response.
// Throughput is one request per cycle while each request yields at most one
// byte and rsp_ready is high. A request that yields more bytes holds
// req_ready low while the single burst register drains them; the next
// request is taken in the cycle the last byte leaves.
// Reset clears the held entity prefix and empties the burst register.
// When the receiver stalls, the current byte is held and req_ready stays low
// until the last byte of the burst is taken.
//------------------------------------------------------------------------------
module xml_entity_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_text_end
);

   xed_pkg::burst_type burst;

   xed_step u_step (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_valid && req_ready),
      .in_byte (req_in_byte),
      .in_end  (req_in_end),
      .burst   (burst)
   );

   xed_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .burst        (burst),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_text_end (rsp_text_end)
   );

endmodule

@@ rtl/xed_step.sv @@
//------------------------------------------------------------------------------
// XML entity decoder match step
// Holds the trie node and turns one request into a burst of decoded bytes.
//------------------------------------------------------------------------------
module xed_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               in_end,
   output xed_pkg::burst_type burst
);

   xed_pkg::node_type match_node_ff, match_node_in;

   always_comb begin
      xed_pkg::node_type nx;
      xed_pkg::node_type nxt;
      xed_pkg::text_type ta;
      xed_pkg::text_type tc;
      logic              fail;
      logic              fresh;
      logic              put_b;
      logic [7:0]        b_val;
      logic [2:0]        la;
      logic [2:0]        lb;
      logic [2:0]        lc;
      logic [2:0]        pos;
      nx    = xed_pkg::child(match_node_ff, in_byte);
      nxt   = xed_pkg::N_NONE;
      fail  = 1'b0;
      fresh = 1'b1;
      put_b = 1'b0;
      b_val = in_byte;
      if (match_node_ff != xed_pkg::N_NONE) begin
         fresh = 1'b0;
         if (in_byte == ";" && xed_pkg::decode(match_node_ff) != 8'h00) begin
            put_b = 1'b1;
            b_val = xed_pkg::decode(match_node_ff);
         end else if (nx != xed_pkg::N_NONE) begin
            nxt = nx;
         end else begin
            fail  = 1'b1;
            fresh = 1'b1;
         end
      end
      if (fresh) begin
         if (in_byte == "&") begin
            nxt = xed_pkg::N_AMP;
         end else begin
            put_b = 1'b1;
         end
      end
      ta = fail ? xed_pkg::node_text(match_node_ff) : '0;
      la = fail ? xed_pkg::node_len(match_node_ff) : 3'd0;
      tc = in_end ? xed_pkg::node_text(nxt) : '0;
      lc = in_end ? xed_pkg::node_len(nxt) : 3'd0;
      lb = {2'b00, put_b};
      match_node_in = in_end ? xed_pkg::N_NONE : nxt;

      burst.bytes = '0;
      for (int i = 0; i < xed_pkg::MaxBurst; i++) begin
         pos = 3'(i) - la - lb;
         if (3'(i) < la) begin
            burst.bytes[i] = ta[i];
         end else if (put_b && 3'(i) == la) begin
            burst.bytes[i] = b_val;
         end else if (pos < 3'(xed_pkg::MaxBurst)) begin
            burst.bytes[i] = tc[pos];
         end
      end
      burst.count    = la + lb + lc;
      burst.text_end = in_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_node_ff <= xed_pkg::N_NONE;
      end else if (accept) begin
         match_node_ff <= match_node_in;
      end
   end

endmodule

@@ rtl/xed_burst.sv @@
//------------------------------------------------------------------------------
// XML entity decoder output burst
// Result register that holds one burst and hands it out a byte per cycle while rsp_ready is high.
//------------------------------------------------------------------------------
module xed_burst (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  xed_pkg::burst_type burst,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_text_end
);

   logic [7:0] buf_ff [xed_pkg::MaxBurst];
   logic [2:0] cnt_ff;
   logic [2:0] idx_ff;
   logic       end_ff;
   logic       valid_ff;
   logic       last;
   logic       take;
   logic       load;

   assign last         = (idx_ff == cnt_ff - 3'd1);
   assign take         = valid_ff && rsp_ready;
   assign req_ready    = !valid_ff || (rsp_ready && last);
   assign load         = req_valid && req_ready && (burst.count != 3'd0);
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = buf_ff[idx_ff];
   assign rsp_run_last = last;
   assign rsp_text_end = last && end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 3'd0;
      end else if (take && last) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else if (take) begin
         idx_ff   <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < xed_pkg::MaxBurst; i++) begin
            buf_ff[i] <= burst.bytes[i];
         end
         cnt_ff <= burst.count;
         end_ff <= burst.text_end;
      end
   end

endmodule

@@ rtl/xed_checker.sv @@
//------------------------------------------------------------------------------
// XML entity decoder checker
// Port-level checks on burst framing, stall behaviour and end-of-text handling.
//------------------------------------------------------------------------------
`include "xml_entity_decoder_macros.svh"

module xed_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_in_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_text_end
);

   `XED_ASSERT_SAME(a_end_is_last, clock, reset, rsp_valid && rsp_text_end, rsp_run_last)
   `XED_ASSERT_NEXT(a_end_yields_rsp, clock, reset,
                    req_valid && req_ready && req_in_end, rsp_valid)
   `XED_ASSERT_NEXT(a_burst_continues, clock, reset,
                    rsp_valid && rsp_ready && !rsp_run_last, rsp_valid)
   `XED_ASSERT_SAME(a_ready_when_free, clock, reset, rsp_valid && req_ready,
                    rsp_ready && rsp_run_last)
   `XED_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last))

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (.*);
